// ===== rtl/afc_pkg.sv =====
// Shared types, constants and tables of the affine calibration fit.
`default_nettype none

package afc_pkg;

  // Field and datapath widths.
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned COEF_W         = 32;
  localparam int unsigned SUM_W          = 40;
  localparam int unsigned MAG_W          = SUM_W;
  localparam int unsigned PROD_W         = 3 * MAG_W;
  localparam int unsigned DET_W          = PROD_W + 4;
  localparam int unsigned NUM_W          = DET_W + 16;
  localparam int unsigned REM_W          = DET_W + 1;
  localparam int unsigned QUO_W          = COEF_W;
  localparam int unsigned CNT_W          = $clog2(NUM_W + 1);
  localparam int unsigned APPLY_PROD_W   = COEF_W + COORD_W;
  localparam int unsigned APPLY_W        = APPLY_PROD_W + 3;
  localparam int unsigned NUM_TERMS      = 6;
  localparam int unsigned NUM_COEF       = 6;
  localparam int unsigned NUM_NSUM       = 5;
  localparam int unsigned NUM_RSUM       = 6;
  localparam int unsigned TERM_W         = 3;
  localparam int unsigned DIDX_W         = 3;
  localparam int unsigned MIN_POINTS     = 3;
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Matrix positions of the three factors of each determinant term.
  localparam logic [3:0] TERM_P [NUM_TERMS] = '{4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] TERM_Q [NUM_TERMS] = '{4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3};
  localparam logic [3:0] TERM_S [NUM_TERMS] = '{4'd8, 4'd6, 4'd7, 4'd6, 4'd7, 4'd8};

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_APPLY = 1'b1
  } action_e;

  typedef enum logic {
    KIND_POINT  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    FIT_OK       = 2'd0,
    FIT_FEW      = 2'd1,
    FIT_SINGULAR = 2'd2,
    FIT_TOO_MANY = 2'd3
  } fit_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_CHECK,
    S_TERM_LOAD,
    S_MUL1,
    S_MID,
    S_MUL2,
    S_TERM_ACC,
    S_DET_DONE,
    S_DIV_LOAD,
    S_DIV,
    S_DIV_FIN,
    S_COMMIT,
    S_REPORT
  } ctrl_state_e;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] est_x;
    logic signed [COORD_W-1:0] est_y;
    logic signed [COORD_W-1:0] true_x;
    logic signed [COORD_W-1:0] true_y;
    logic                      last_pair;
  } afc_in_t;

  typedef struct packed {
    logic                      result_kind;
    logic signed [COORD_W-1:0] cal_x;
    logic signed [COORD_W-1:0] cal_y;
    logic [1:0]                fit_status;
  } afc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_pair;
    logic              apply_cap;
    logic              apply_out;
    logic              report;
    fit_status_e       status;
    logic              term_load;
    logic              mul_step;
    logic              mul_reload;
    logic              term_acc;
    logic              det_store;
    logic              div_load;
    logic              div_step;
    logic              div_finish;
    logic              commit;
    logic [DIDX_W-1:0] det_idx;
    logic [TERM_W-1:0] term;
  } afc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic count_over;
    logic count_low;
    logic acc_zero;
  } afc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/affine_calibration_fit.sv =====
// Top level of the affine calibration fit: controller plus datapath.
//
// Input channel (in_valid_i / in_ready_o, in_data_i) carries load and apply
// items; output channel (out_valid_o / out_ready_i, out_data_o) returns one
// result per apply item and one status result per final load pair.
// A load item without the final-pair mark gives no result;
// such loads transfer back to back while the result slot is free.
// An apply item's products are registered, then summed, rounded and saturated
// into the result register; the next item can transfer only after that, once
// the controller is back in idle and the result slot is free.
// A final load pair starts the solve. Too few or too many pairs report from the
// check state; a singular matrix after the first determinant. A full solve
// computes seven 3x3 determinants of six terms, each term two 40-step shift-add
// multiplies, and after each of the last six a 140-step restoring division.
// No input is taken during a solve.
// Reset restores the identity transform and clears the sums and pair count.
// When the receiver stalls, the result waits in the output register and no
// new item is taken until that slot frees.
`default_nettype none

module affine_calibration_fit import afc_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire afc_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output afc_out_t     out_data_o
);

  afc_cmd_t cmd;
  afc_sts_t sts;

  afc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_last_i   (in_data_i.last_pair),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  afc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/afc_ctrl.sv =====
// Controller state machine of the affine calibration fit.
`default_nettype none

module afc_ctrl import afc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_action_i,
  input  wire logic     in_last_i,
  input  wire afc_sts_t sts_i,
  output logic          in_ready_o,
  output afc_cmd_t      cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [TERM_W-1:0] term_q;
  logic [DIDX_W-1:0] didx_q;
  fit_status_e       status_q;
  logic              accept;

  // Items are taken only in idle, and only when the result slot is free.
  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_action_i == ACT_APPLY) begin
            state_d = S_APPLY;
          end else if (in_last_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_APPLY:     state_d = S_IDLE;
      S_CHECK: begin
        if (sts_i.count_over || sts_i.count_low) begin
          state_d = S_REPORT;
        end else begin
          state_d = S_TERM_LOAD;
        end
      end
      S_TERM_LOAD: state_d = S_MUL1;
      S_MUL1: begin
        if (cnt_q == CNT_W'(MAG_W - 1)) state_d = S_MID;
      end
      S_MID:       state_d = S_MUL2;
      S_MUL2: begin
        if (cnt_q == CNT_W'(MAG_W - 1)) state_d = S_TERM_ACC;
      end
      S_TERM_ACC: begin
        if (term_q == TERM_W'(NUM_TERMS - 1)) begin
          state_d = S_DET_DONE;
        end else begin
          state_d = S_TERM_LOAD;
        end
      end
      S_DET_DONE: begin
        if (didx_q == '0) begin
          state_d = sts_i.acc_zero ? S_REPORT : S_TERM_LOAD;
        end else begin
          state_d = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD:  state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == CNT_W'(NUM_W - 1)) state_d = S_DIV_FIN;
      end
      S_DIV_FIN: begin
        if (didx_q == DIDX_W'(NUM_COEF)) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_TERM_LOAD;
        end
      end
      S_COMMIT:    state_d = S_REPORT;
      S_REPORT:    state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.status     = status_q;
    cmd_o.det_idx    = didx_q;
    cmd_o.term       = term_q;
    cmd_o.load_pair  = accept && (in_action_i == ACT_LOAD);
    cmd_o.apply_cap  = accept && (in_action_i == ACT_APPLY);
    case (state_q)
      S_APPLY:     cmd_o.apply_out  = 1'b1;
      S_TERM_LOAD: cmd_o.term_load  = 1'b1;
      S_MUL1:      cmd_o.mul_step   = 1'b1;
      S_MID:       cmd_o.mul_reload = 1'b1;
      S_MUL2:      cmd_o.mul_step   = 1'b1;
      S_TERM_ACC:  cmd_o.term_acc   = 1'b1;
      S_DET_DONE:  cmd_o.det_store  = (didx_q == '0);
      S_DIV_LOAD:  cmd_o.div_load   = 1'b1;
      S_DIV:       cmd_o.div_step   = 1'b1;
      S_DIV_FIN:   cmd_o.div_finish = 1'b1;
      S_COMMIT:    cmd_o.commit     = 1'b1;
      S_REPORT:    cmd_o.report     = 1'b1;
      default:     ;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step counters and the fit status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      term_q   <= '0;
      didx_q   <= '0;
      status_q <= FIT_OK;
    end else begin
      case (state_q)
        S_CHECK: begin
          term_q <= '0;
          didx_q <= '0;
          if (sts_i.count_over) begin
            status_q <= FIT_TOO_MANY;
          end else if (sts_i.count_low) begin
            status_q <= FIT_FEW;
          end
        end
        S_TERM_LOAD, S_MID, S_DIV_LOAD: cnt_q <= '0;
        S_MUL1, S_MUL2, S_DIV:          cnt_q <= cnt_q + 1'b1;
        S_TERM_ACC: begin
          if (term_q == TERM_W'(NUM_TERMS - 1)) begin
            term_q <= '0;
          end else begin
            term_q <= term_q + 1'b1;
          end
        end
        S_DET_DONE: begin
          if (didx_q == '0) begin
            if (sts_i.acc_zero) begin
              status_q <= FIT_SINGULAR;
            end else begin
              didx_q <= DIDX_W'(1);
            end
          end
        end
        S_DIV_FIN: begin
          if (didx_q != DIDX_W'(NUM_COEF)) didx_q <= didx_q + 1'b1;
        end
        S_COMMIT: status_q <= FIT_OK;
        default: ;
      endcase
    end
  end

  // A final load always starts the solve on the next cycle.
  a_last_starts_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_action_i == ACT_LOAD && in_last_i) |=> (state_q == S_CHECK))
    else $error("final pair did not start the solve");

  // The status result never finds the result slot occupied.
  a_report_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPORT) |-> sts_i.out_free)
    else $error("status report while result slot busy");

  // Term and determinant counters stay in range.
  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (term_q < TERM_W'(NUM_TERMS)) && (didx_q <= DIDX_W'(NUM_COEF)))
    else $error("solve counter out of range");

  // Coefficients are only committed after a successful solve of all six.
  a_commit_after_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> (didx_q == DIDX_W'(NUM_COEF)))
    else $error("commit before all coefficients were solved");

endmodule

`default_nettype wire

// ===== rtl/afc_dp.sv =====
// Datapath of the affine calibration fit: sums, serial multiplier and divider, apply.
`default_nettype none

module afc_dp import afc_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire afc_in_t  in_data_i,
  input  wire afc_cmd_t cmd_i,
  output afc_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output afc_out_t      out_data_o
);

  localparam int unsigned PC_W = $clog2(MAX_POINTS + 2);

  logic [PC_W-1:0]             count_q;
  logic [SUM_W-1:0]            nsum_q [NUM_NSUM];
  logic [SUM_W-1:0]            rsum_q [NUM_RSUM];
  logic signed [COEF_W-1:0]    coef_q [NUM_COEF];
  logic signed [COEF_W-1:0]    ncoef_q [NUM_COEF];
  logic [PROD_W-1:0]           mul_a_q, mul_p_q;
  logic [MAG_W-1:0]            mul_b_q, s_mag_q;
  logic                        t_neg_q;
  logic signed [DET_W-1:0]     acc_q, det_q;
  logic [NUM_W-1:0]            num_q;
  logic [REM_W-1:0]            rem_q;
  logic [DET_W-1:0]            den_q;
  logic [QUO_W-1:0]            quo_q;
  logic                        q_ovf_q, q_neg_q;
  logic signed [APPLY_PROD_W-1:0] pax_q, pby_q, pcx_q, pdy_q;
  logic                        out_valid_q;
  afc_out_t                    out_data_q;

  function automatic logic [MAG_W-1:0] mag(input logic [SUM_W-1:0] v);
    mag = v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [APPLY_W-1:0] s);
    logic signed [APPLY_W-17:0] v;
    v = $signed(s[APPLY_W-1:16]);
    if (v > 32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[COORD_W-1:0];
    end
  endfunction

  // Status to the controller.
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.count_over = (count_q > PC_W'(MAX_POINTS));
  assign sts_o.count_low  = (count_q < PC_W'(MIN_POINTS));
  assign sts_o.acc_zero   = (acc_q == '0);

  // Products of one calibration pair.
  logic signed [2*COORD_W-1:0] np_xx, np_xy, np_yy, rp_tx_x, rp_tx_y, rp_ty_x, rp_ty_y;
  logic [SUM_W-1:0]            np [NUM_NSUM];
  logic [SUM_W-1:0]            rp [NUM_RSUM];

  always_comb begin
    np_xx   = in_data_i.est_x * in_data_i.est_x;
    np_xy   = in_data_i.est_x * in_data_i.est_y;
    np_yy   = in_data_i.est_y * in_data_i.est_y;
    rp_tx_x = in_data_i.true_x * in_data_i.est_x;
    rp_tx_y = in_data_i.true_x * in_data_i.est_y;
    rp_ty_x = in_data_i.true_y * in_data_i.est_x;
    rp_ty_y = in_data_i.true_y * in_data_i.est_y;
    np[0] = SUM_W'(np_xx);
    np[1] = SUM_W'(np_xy);
    np[2] = SUM_W'(np_yy);
    np[3] = SUM_W'(in_data_i.est_x);
    np[4] = SUM_W'(in_data_i.est_y);
    rp[0] = SUM_W'(rp_tx_x);
    rp[1] = SUM_W'(rp_tx_y);
    rp[2] = SUM_W'(in_data_i.true_x);
    rp[3] = SUM_W'(rp_ty_x);
    rp[4] = SUM_W'(rp_ty_y);
    rp[5] = SUM_W'(in_data_i.true_y);
  end

  // Pair count and running sums; cleared by reset and by the status report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NUM_NSUM; i++) nsum_q[i] <= '0;
      for (int i = 0; i < NUM_RSUM; i++) rsum_q[i] <= '0;
    end else if (cmd_i.report) begin
      count_q <= '0;
      for (int i = 0; i < NUM_NSUM; i++) nsum_q[i] <= '0;
      for (int i = 0; i < NUM_RSUM; i++) rsum_q[i] <= '0;
    end else if (cmd_i.load_pair) begin
      if (count_q < PC_W'(MAX_POINTS)) begin
        count_q <= count_q + 1'b1;
        for (int i = 0; i < NUM_NSUM; i++) nsum_q[i] <= nsum_q[i] + np[i];
        for (int i = 0; i < NUM_RSUM; i++) rsum_q[i] <= rsum_q[i] + rp[i];
      end else begin
        count_q <= PC_W'(MAX_POINTS + 1);
      end
    end
  end

  // Working matrix: normal matrix, with one column replaced by a right-hand side.
  logic [SUM_W-1:0]  w [9];
  logic [DIDX_W-1:0] cidx;
  logic              row;
  logic [1:0]        kcol;
  logic [SUM_W-1:0]  op_p, op_q, op_s;

  always_comb begin
    cidx = cmd_i.det_idx - DIDX_W'(1);
    row  = (cidx >= DIDX_W'(3));
    kcol = row ? 2'(cidx - DIDX_W'(3)) : cidx[1:0];
    w[0] = nsum_q[0];
    w[1] = nsum_q[1];
    w[2] = nsum_q[3];
    w[3] = nsum_q[1];
    w[4] = nsum_q[2];
    w[5] = nsum_q[4];
    w[6] = nsum_q[3];
    w[7] = nsum_q[4];
    w[8] = {{(SUM_W-PC_W){1'b0}}, count_q};
    if (cmd_i.det_idx != '0) begin
      for (int i = 0; i < 3; i++) begin
        w[i * 3 + int'(kcol)] = rsum_q[row ? i + 3 : i];
      end
    end
    op_p = w[TERM_P[cmd_i.term]];
    op_q = w[TERM_Q[cmd_i.term]];
    op_s = w[TERM_S[cmd_i.term]];
  end

  // Shift-add multiplier and determinant accumulator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.term_load) begin
      mul_a_q <= PROD_W'(mag(op_p));
      mul_b_q <= mag(op_q);
      mul_p_q <= '0;
      s_mag_q <= mag(op_s);
      t_neg_q <= (cmd_i.term >= TERM_W'(3)) ^ op_p[SUM_W-1] ^ op_q[SUM_W-1] ^ op_s[SUM_W-1];
      if (cmd_i.term == '0) acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mul_b_q[0]) mul_p_q <= mul_p_q + mul_a_q;
      mul_a_q <= {mul_a_q[PROD_W-2:0], 1'b0};
      mul_b_q <= {1'b0, mul_b_q[MAG_W-1:1]};
    end else if (cmd_i.mul_reload) begin
      mul_a_q <= mul_p_q;
      mul_b_q <= s_mag_q;
      mul_p_q <= '0;
    end else if (cmd_i.term_acc) begin
      if (t_neg_q) begin
        acc_q <= acc_q - $signed({{(DET_W-PROD_W){1'b0}}, mul_p_q});
      end else begin
        acc_q <= acc_q + $signed({{(DET_W-PROD_W){1'b0}}, mul_p_q});
      end
    end
    if (cmd_i.det_store) det_q <= acc_q;
  end

  // Restoring divider with rounding and saturation to Q16.16 for a, b, c, d and Q24.8 for the offsets e, f.
  logic [DET_W-1:0] acc_mag, det_mag;
  logic [REM_W-1:0] rem_shift;
  logic             rem_ge;
  logic             rnd;
  logic [QUO_W:0]   qr;
  logic             q_big;
  logic signed [COEF_W-1:0] coef_new;

  always_comb begin
    acc_mag   = acc_q[DET_W-1] ? (~acc_q + 1'b1) : acc_q;
    det_mag   = det_q[DET_W-1] ? (~det_q + 1'b1) : det_q;
    rem_shift = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
    rem_ge    = (rem_shift >= {1'b0, den_q});
    rnd       = ({rem_q, 1'b0} >= {2'b00, den_q});
    qr        = {1'b0, quo_q} + (QUO_W+1)'(rnd);
    q_big     = q_ovf_q || qr[QUO_W];
    if (q_neg_q) begin
      if (q_big || (qr[QUO_W-1] && (qr[QUO_W-2:0] != '0))) begin
        coef_new = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
        coef_new = ~qr[QUO_W-1:0] + 1'b1;
      end
    end else begin
      if (q_big || qr[QUO_W-1]) begin
        coef_new = {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
        coef_new = qr[QUO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      if (kcol == 2'd2) begin
        num_q <= NUM_W'(acc_mag) << 8;
      end else begin
        num_q <= NUM_W'(acc_mag) << 16;
      end
      den_q   <= det_mag;
      q_neg_q <= acc_q[DET_W-1] ^ det_q[DET_W-1];
      rem_q   <= '0;
      quo_q   <= '0;
      q_ovf_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      rem_q   <= rem_ge ? (rem_shift - {1'b0, den_q}) : rem_shift;
      quo_q   <= {quo_q[QUO_W-2:0], rem_ge};
      q_ovf_q <= q_ovf_q | quo_q[QUO_W-1];
      num_q   <= {num_q[NUM_W-2:0], 1'b0};
    end
    if (cmd_i.div_finish) ncoef_q[cidx] <= coef_new;
  end

  // Active coefficients a, b, e, c, d, f; identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
      coef_q[0] <= COEF_W'(65536);
      coef_q[4] <= COEF_W'(65536);
    end else if (cmd_i.commit) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= ncoef_q[i];
    end
  end

  // Apply: products first, then sum, round and saturate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_cap) begin
      pax_q <= coef_q[0] * in_data_i.est_x;
      pby_q <= coef_q[1] * in_data_i.est_y;
      pcx_q <= coef_q[3] * in_data_i.est_x;
      pdy_q <= coef_q[4] * in_data_i.est_y;
    end
  end

  logic signed [APPLY_W-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = APPLY_W'(pax_q) + APPLY_W'(pby_q) + (APPLY_W'(coef_q[2]) <<< 8)
          + APPLY_W'(32768);
    sum_y = APPLY_W'(pcx_q) + APPLY_W'(pdy_q) + (APPLY_W'(coef_q[5]) <<< 8)
          + APPLY_W'(32768);
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.apply_out || cmd_i.report) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_out) begin
      out_data_q.result_kind <= KIND_POINT;
      out_data_q.cal_x       <= sat16(sum_x);
      out_data_q.cal_y       <= sat16(sum_y);
      out_data_q.fit_status  <= '0;
    end else if (cmd_i.report) begin
      out_data_q.result_kind <= KIND_STATUS;
      out_data_q.cal_x       <= '0;
      out_data_q.cal_y       <= '0;
      out_data_q.fit_status  <= cmd_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
